@@ src/pip_pkg.sv @@
package pip_pkg;

	typedef enum logic [1:0] {
		LOC_OUTSIDE = 2'd0,
		LOC_INSIDE  = 2'd1,
		LOC_EDGE    = 2'd2,
		LOC_VERTEX  = 2'd3
	} loc_t;

endpackage

@@ src/pip_in_if.sv @@
interface pip_in_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] query_x;
	logic signed [COORD_BITS-1:0] query_y;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         last_vertex;

	modport source (output valid, query_x, query_y, vertex_x, vertex_y, last_vertex,
		input ready);
	modport sink (input valid, query_x, query_y, vertex_x, vertex_y, last_vertex,
		output ready);
endinterface

@@ src/pip_out_if.sv @@
interface pip_out_if
	import pip_pkg::*;
();
	logic valid;
	logic ready;
	logic contains;
	loc_t location;

	modport source (output valid, contains, location, input ready);
	modport sink (input valid, contains, location, output ready);
endinterface

@@ src/point_in_polygon_with_boundary_core.sv @@
// Crossing-number point-in-polygon test with boundary detection.
// vtx: one request per polygon vertex, in order, each carrying the query point
//   and the vertex; last_vertex marks the final vertex and closes the polygon.
// res: one request per polygon, issued for the final vertex: location
//   (outside, inside, on edge, on vertex) and contains (location not outside).
// Throughput: one vertex per cycle. Each vertex passes an input register (s1),
//   where the edge differences and the four cross-product terms are formed, and
//   a product register (s2), where the product signs update the right and left
//   ray parities; the result then sits in the output register.
// A final vertex goes from s1 to s2 and then into the output register, which drives res.valid.
// While a result waits in the output register, non-final vertices keep flowing;
//   only a second final vertex reaching s2 holds the pipeline, and vtx.ready
//   drops once s1 and s2 are both held.
// Reset clears all valids and parities; the next vertex starts a new polygon.
module point_in_polygon_with_boundary_core
	import pip_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	pip_in_if.sink    vtx,
	pip_out_if.source res
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;

	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] qx_s1, qy_s1, vx_s1, vy_s1;
	logic                         last_s1;

	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic                         at_start_q;
	logic                         right_q, left_q, hit_q;

	logic                         valid_s2, last_s2, hit_s2;
	logic signed [PW-1:0]         rp1_s2, rp2_s2, cp1_s2, cp2_s2;
	logic                         rcr_s2, rcl_s2, rden_s2;
	logic                         ccr_s2, ccl_s2, cden_s2;

	logic                         out_valid_q, out_contains_q;
	loc_t                         out_loc_q;

	logic out_free, adv2, adv1;

	assign out_free = !out_valid_q || res.ready;
	assign adv2     = !valid_s2 || !last_s2 || out_free;
	assign adv1     = !valid_s1 || adv2;
	assign vtx.ready = adv1;

	// stage 1 arithmetic
	logic signed [DW-1:0] cx, cy, bx, by, fx, fy;
	logic                 hit_c;

	always_comb begin
		cx = DW'(vx_s1) - DW'(qx_s1);
		cy = DW'(vy_s1) - DW'(qy_s1);
		bx = DW'(prev_x_q) - DW'(qx_s1);
		by = DW'(prev_y_q) - DW'(qy_s1);
		// a first vertex is also the closing vertex
		fx = at_start_q ? cx : DW'(first_x_q) - DW'(qx_s1);
		fy = at_start_q ? cy : DW'(first_y_q) - DW'(qy_s1);
		hit_c = (cx == '0) && (cy == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= vtx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			qx_s1   <= vtx.query_x;
			qy_s1   <= vtx.query_y;
			vx_s1   <= vtx.vertex_x;
			vy_s1   <= vtx.vertex_y;
			last_s1 <= vtx.last_vertex;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q  <= '0;
			first_y_q  <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			at_start_q <= 1'b1;
		end else if (valid_s1 && adv2) begin
			if (at_start_q) begin
				first_x_q <= vx_s1;
				first_y_q <= vy_s1;
			end
			prev_x_q   <= vx_s1;
			prev_y_q   <= vy_s1;
			at_start_q <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	// edge b->a: regular edge a=cur, b=prev; closing edge a=first, b=cur
	always_ff @(posedge clk) begin
		if (adv2) begin
			last_s2 <= last_s1;
			hit_s2  <= hit_c;
			rp1_s2  <= cx * by;
			rp2_s2  <= bx * cy;
			rcr_s2  <= !at_start_q && ((cy > 0) != (by > 0));
			rcl_s2  <= !at_start_q && ((cy < 0) != (by < 0));
			rden_s2 <= by > cy;
			cp1_s2  <= fx * cy;
			cp2_s2  <= cx * fy;
			ccr_s2  <= last_s1 && ((fy > 0) != (cy > 0));
			ccl_s2  <= last_s1 && ((fy < 0) != (cy < 0));
			cden_s2 <= cy > fy;
		end
	end

	// stage 2: cross-product signs and parity update
	logic signed [XW-1:0] rx, cxp;
	logic                 r_nz, r_pos, c_nz, c_pos;
	logic                 tog_r, tog_l, right_n, left_n, hit_n;
	loc_t                 loc_n;

	always_comb begin
		rx    = XW'(rp1_s2) - XW'(rp2_s2);
		cxp   = XW'(cp1_s2) - XW'(cp2_s2);
		r_nz  = rx != '0;
		r_pos = r_nz && !rx[XW-1];
		c_nz  = cxp != '0;
		c_pos = c_nz && !cxp[XW-1];
		tog_r = (rcr_s2 && r_nz && (r_pos == rden_s2))
			^ (ccr_s2 && c_nz && (c_pos == cden_s2));
		tog_l = (rcl_s2 && r_nz && (r_pos != rden_s2))
			^ (ccl_s2 && c_nz && (c_pos != cden_s2));
		right_n = right_q ^ tog_r;
		left_n  = left_q ^ tog_l;
		hit_n   = hit_q || hit_s2;
		if (hit_n) begin
			loc_n = LOC_VERTEX;
		end else if (right_n != left_n) begin
			loc_n = LOC_EDGE;
		end else if (right_n) begin
			loc_n = LOC_INSIDE;
		end else begin
			loc_n = LOC_OUTSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= 1'b0;
			left_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else if (valid_s2 && adv2) begin
			right_q <= right_n && !last_s2;
			left_q  <= left_n && !last_s2;
			hit_q   <= hit_n && !last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s2 && last_s2 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && last_s2 && out_free) begin
			out_loc_q      <= loc_n;
			out_contains_q <= loc_n != LOC_OUTSIDE;
		end
	end

	assign res.valid    = out_valid_q;
	assign res.location = out_loc_q;
	assign res.contains = out_contains_q;

endmodule

@@ src/pip_checker.sv @@
module pip_port_checker
	import pip_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic vtx_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_contains,
	input loc_t res_location
);
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_location) && $stable(res_contains))
		else $error("result changed while stalled");

	a_contains: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_contains == (res_location != LOC_OUTSIDE)))
		else $error("contains disagrees with location");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> vtx_ready)
		else $error("input stalled with empty output");
endmodule

bind point_in_polygon_with_boundary_core pip_port_checker u_pip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.vtx_ready    (vtx.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_contains (res.contains),
	.res_location (res.location)
);

@@ tb/sv/pip_checker.sv @@
module pip_checker
	import pip_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	pip_in_if    vtx,
	pip_out_if   res,
	output int   pending,
	output int   errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [COORD_BITS-1:0]   coord_t;
	typedef logic signed [COORD_BITS:0]     diff_t;
	typedef logic signed [2*COORD_BITS+3:0] prod_t;

	typedef struct packed {
		logic contains;
		loc_t location;
	} verdict_t;

	verdict_t expected_verdicts[$];
	verdict_t oldest;

	coord_t first_x, first_y, prev_x, prev_y;
	logic   right_odd, left_odd, vertex_hit;
	logic   at_start = 1'b1;

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic void clear_polygon();
		first_x    = '0;
		first_y    = '0;
		prev_x     = '0;
		prev_y     = '0;
		right_odd  = 1'b0;
		left_odd   = 1'b0;
		vertex_hit = 1'b0;
		at_start   = 1'b1;
	endfunction

	// edge from b to a, both relative to the query point
	function automatic void count_crossings(diff_t ax, diff_t ay, diff_t bx, diff_t by);
		prod_t cr;
		int    turn, rising;
		cr     = ax * by - bx * ay;
		turn   = (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
		rising = (by > ay) ? 1 : -1;
		if (((ay > 0) != (by > 0)) && turn != 0 && turn == rising)
			right_odd = ~right_odd;
		if (((ay < 0) != (by < 0)) && turn != 0 && turn != rising)
			left_odd = ~left_odd;
	endfunction

	function automatic void take_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy,
		logic last);
		diff_t    cx, cy, px, py, fx, fy;
		verdict_t v;
		cx = vx - qx;
		cy = vy - qy;
		px = prev_x - qx;
		py = prev_y - qy;
		if (cx == 0 && cy == 0)
			vertex_hit = 1'b1;
		if (at_start) begin
			first_x = vx;
			first_y = vy;
		end else begin
			count_crossings(cx, cy, px, py);
		end
		prev_x   = vx;
		prev_y   = vy;
		at_start = 1'b0;
		if (last) begin
			fx = first_x - qx;
			fy = first_y - qy;
			count_crossings(fx, fy, cx, cy);
			if (vertex_hit)
				v.location = LOC_VERTEX;
			else if (right_odd != left_odd)
				v.location = LOC_EDGE;
			else if (right_odd)
				v.location = LOC_INSIDE;
			else
				v.location = LOC_OUTSIDE;
			v.contains = (v.location != LOC_OUTSIDE);
			expected_verdicts.push_back(v);
			clear_polygon();
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_polygon();
			expected_verdicts.delete();
		end else begin
			if (res.valid && res.ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected result: contains %0b location %0d",
						res.contains, res.location);
					errors++;
				end else begin
					oldest = expected_verdicts.pop_front();
					if (res.contains !== oldest.contains) begin
						$error("contains: expected %0b, actual %0b",
							oldest.contains, res.contains);
						errors++;
					end
					if (res.location !== oldest.location) begin
						$error("location: expected %0d, actual %0d",
							oldest.location, res.location);
						errors++;
					end
				end
			end
			if (vtx.valid && vtx.ready)
				take_vertex(vtx.query_x, vtx.query_y, vtx.vertex_x, vtx.vertex_y,
					vtx.last_vertex);
		end
		pending <= expected_verdicts.size();
	end

endmodule

@@ tb/sv/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS  = 16;
	localparam int ITEMS       = 750;
	localparam int CALM_ITEMS  = 60;
	localparam int QUIET_LIMIT = 2000;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	logic   clk    = 1'b0;
	logic   arst_n = 1'b0;
	logic   bursty = 1'b1;
	int     pending, errors;
	int     sent = 0;
	coord_t poly_x[16], poly_y[16];

	pip_in_if #(.COORD_BITS(COORD_BITS)) vtx ();
	pip_out_if res ();

	point_in_polygon_with_boundary_core #(.COORD_BITS(COORD_BITS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx),
		.res    (res)
	);

	pip_checker #(.COORD_BITS(COORD_BITS)) chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.vtx     (vtx),
		.res     (res),
		.pending (pending),
		.errors  (errors)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic coord_t rand_coord(int span);
		if (span == 0) begin
			if ($urandom_range(0, 15) == 0)
				return $urandom_range(0, 1) ? coord_t'(32767) : coord_t'(-32768);
			return coord_t'($urandom);
		end
		return coord_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic send_vertex(coord_t qx, coord_t qy, coord_t vx, coord_t vy, logic last);
		if (bursty && $urandom_range(0, 5) == 0) begin
			vtx.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		vtx.valid       <= 1'b1;
		vtx.query_x     <= qx;
		vtx.query_y     <= qy;
		vtx.vertex_x    <= vx;
		vtx.vertex_y    <= vy;
		vtx.last_vertex <= last;
		do @(posedge clk); while (!vtx.ready);
		sent++;
	endtask

	// result backpressure
	initial begin
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (bursty && $urandom_range(0, 7) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			res.ready <= 1'b1;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((vtx.valid && vtx.ready) || (res.valid && res.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("** point_in_polygon_with_boundary_core: FAILED **");
		$finish;
	end

	initial begin
		int     n, span, mode, i, j, dx, dy;
		coord_t qx, qy;
		vtx.valid       <= 1'b0;
		vtx.query_x     <= '0;
		vtx.query_y     <= '0;
		vtx.vertex_x    <= '0;
		vtx.vertex_y    <= '0;
		vtx.last_vertex <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-range triangle: inside, outside, on a corner, on the bottom edge
		send_vertex(0, 0, -32768, -32768, 0);
		send_vertex(0, 0, 32767, -32768, 0);
		send_vertex(0, 0, 0, 32767, 1);
		send_vertex(32767, 32767, -32768, -32768, 0);
		send_vertex(32767, 32767, 32767, -32768, 0);
		send_vertex(32767, 32767, 0, 32767, 1);
		send_vertex(-32768, -32768, -32768, -32768, 0);
		send_vertex(-32768, -32768, 32767, -32768, 0);
		send_vertex(-32768, -32768, 0, 32767, 1);
		send_vertex(0, -32768, -32768, -32768, 0);
		send_vertex(0, -32768, 32767, -32768, 0);
		send_vertex(0, -32768, 0, 32767, 1);
		// lone vertex, hit and miss
		send_vertex(5, 5, 5, 5, 1);
		send_vertex(-1, 0, 5, 5, 1);
		// point on an edge
		send_vertex(5, 0, 0, 0, 0);
		send_vertex(5, 0, 10, 0, 0);
		send_vertex(5, 0, 0, 10, 1);
		// two-vertex polygon through the point
		send_vertex(0, 0, -4, -4, 0);
		send_vertex(0, 0, 4, 4, 1);
		// query moves within one polygon
		send_vertex(0, 0, -10, -10, 0);
		send_vertex(1, 2, 10, -10, 0);
		send_vertex(-3, 1, 10, 10, 0);
		send_vertex(20, 0, -10, 10, 1);

		while (sent < ITEMS) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
			case ($urandom_range(0, 3))
				0: span = 0;
				1: span = 1000;
				default: span = 8;
			endcase
			for (i = 0; i < n; i++) begin
				poly_x[i] = rand_coord(span);
				poly_y[i] = rand_coord(span);
			end
			qx   = rand_coord(span);
			qy   = rand_coord(span);
			mode = $urandom_range(0, 3);
			i    = $urandom_range(0, n - 1);
			if (mode == 2) begin
				qx = poly_x[i];
				qy = poly_y[i];
			end else if (mode == 3 && span != 0 && n > 1) begin
				j         = (i + 1) % n;
				dx        = $urandom_range(0, 8) - 4;
				dy        = $urandom_range(0, 8) - 4;
				poly_x[j] = coord_t'(poly_x[i] + 2 * dx);
				poly_y[j] = coord_t'(poly_y[i] + 2 * dy);
				qx        = coord_t'(poly_x[i] + dx);
				qy        = coord_t'(poly_y[i] + dy);
			end
			for (i = 0; i < n; i++) begin
				if (span != 0 && $urandom_range(0, 15) == 0)
					send_vertex(rand_coord(span), rand_coord(span), poly_x[i], poly_y[i],
						i == n - 1);
				else
					send_vertex(qx, qy, poly_x[i], poly_y[i], i == n - 1);
			end
			if (sent >= ITEMS - CALM_ITEMS)
				bursty <= 1'b0;
		end
		vtx.valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("** point_in_polygon_with_boundary_core: PASSED **");
		else
			$display("** point_in_polygon_with_boundary_core: FAILED **");
		$finish;
	end

endmodule
